FILE: hw/rtl/tle_pkg.sv
// tle_pkg: shared constants, types and the erase echo table of the terminal line editor
// used by tle_emit and terminal_line_editor_core; depends on nothing

package tle_pkg;

   localparam int unsigned BUF_DEPTH = 256;

   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_LF      = 8'd10;
   localparam logic [7:0] CHAR_BS      = 8'd8;
   localparam logic [7:0] CHAR_DEL     = 8'd127;
   localparam logic [7:0] CHAR_ESC     = 8'd27;
   localparam logic [7:0] CHAR_BRACKET = 8'd91;
   localparam logic [7:0] CHAR_CUR_D   = 8'd68;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_NUL     = 8'd0;

   localparam logic [8:0] CAP_RESET = 9'd256;
   localparam logic [8:0] CAP_MIN   = 9'd2;
   localparam logic [8:0] CAP_MAX   = 9'((BUF_DEPTH < 256) ? BUF_DEPTH : 256);

   localparam logic CSR_LINE_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      RUN_ECHO,
      RUN_ERASE,
      RUN_STORE
   } run_kind_type;

   // one decoded item, everything the result sequencer needs
   typedef struct packed {
      run_kind_type kind;
      logic [7:0]   rx_char;
      logic [7:0]   index;
      logic [7:0]   next;
      logic         done;
   } run_type;

   // ESC [ D space ESC [ D
   function automatic logic [7:0] erase_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0, 3'd4: b = CHAR_ESC;
         3'd1, 3'd5: b = CHAR_BRACKET;
         3'd2, 3'd6: b = CHAR_CUR_D;
         3'd3:       b = CHAR_SPACE;
         default:    b = CHAR_NUL;
      endcase
      return b;
   endfunction

endpackage

FILE: hw/rtl/tle_emit.sv
// tle_emit: result sequencer, holds one decoded item and sends its results one per cycle while rsp_stall is low
// depends on tle_pkg

module tle_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             desc_valid,
   input  tle_pkg::run_type desc,
   output logic             desc_take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_echo_valid,
   output logic [7:0]       rsp_echo_byte,
   output logic             rsp_write_valid,
   output logic [7:0]       rsp_write_index,
   output logic [7:0]       rsp_write_char,
   output logic             rsp_line_done,
   output logic [7:0]       rsp_line_length,
   output logic             rsp_last_of_run
);

   logic             valid_ff, valid_in;
   logic [2:0]       step_ff, step_in;
   tle_pkg::run_type run_ff;
   logic [2:0]       last_step;
   logic             is_last;
   logic             rsp_accept;

   always_comb begin
      case (run_ff.kind)
         tle_pkg::RUN_ERASE: last_step = 3'd7;
         tle_pkg::RUN_STORE: last_step = run_ff.done ? 3'd1 : 3'd0;
         default:            last_step = 3'd0;
      endcase
   end

   assign is_last    = (step_ff == last_step);
   assign rsp_valid  = valid_ff;
   assign rsp_accept = valid_ff && !rsp_stall;
   assign desc_take  = !valid_ff || (rsp_accept && is_last);

   always_comb begin
      valid_in = valid_ff;
      step_in  = step_ff;
      if (desc_take) begin
         valid_in = desc_valid;
         step_in  = 3'd0;
      end else if (rsp_accept) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_take) begin
         run_ff <= desc;
      end
   end

   always_comb begin
      rsp_echo_valid  = 1'b0;
      rsp_echo_byte   = tle_pkg::CHAR_NUL;
      rsp_write_valid = 1'b0;
      rsp_write_index = 8'd0;
      rsp_write_char  = tle_pkg::CHAR_NUL;
      rsp_line_done   = 1'b0;
      rsp_line_length = 8'd0;
      rsp_last_of_run = is_last;
      if (step_ff == 3'd0) begin
         rsp_echo_valid = 1'b1;
         rsp_echo_byte  = run_ff.rx_char;
         if (run_ff.kind == tle_pkg::RUN_STORE) begin
            rsp_write_valid = 1'b1;
            rsp_write_index = run_ff.index;
            rsp_write_char  = run_ff.rx_char;
         end
      end else if (run_ff.kind == tle_pkg::RUN_ERASE) begin
         rsp_echo_valid = 1'b1;
         rsp_echo_byte  = tle_pkg::erase_byte(step_ff - 3'd1);
      end else begin
         // terminating nul of a finished line
         rsp_write_valid = 1'b1;
         rsp_write_index = run_ff.next;
         rsp_line_done   = 1'b1;
         rsp_line_length = run_ff.next;
      end
   end

endmodule

FILE: hw/rtl/terminal_line_editor_core.sv
// terminal_line_editor_core: top level of the terminal line editor, item decode and line state
// depends on tle_pkg and tle_emit
//
// channel   direction  handshake              payload
// req       in         req_valid/req_stall    req_received_char
// rsp       out        rsp_valid/rsp_stall    echo, buffer write and line report fields
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// an item gives 1, 2 or 8 results, sent one per cycle by the result sequencer while rsp_stall
// is low; an accepted item goes to the decode register and then to the sequencer's item register
// a decode register in front of the sequencer takes the next item while results still go out
// reset clears the line count and the carriage-return flag and sets the capacity to 256
// rsp_stall holds the current result; req_stall rises once the decode register is also full

module terminal_line_editor_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_received_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_echo_valid,
   output logic [7:0] rsp_echo_byte,
   output logic       rsp_write_valid,
   output logic [7:0] rsp_write_index,
   output logic [7:0] rsp_write_char,
   output logic       rsp_line_done,
   output logic [7:0] rsp_line_length,
   output logic       rsp_last_of_run,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [8:0] csr_write_data
);

   logic [8:0]       cap_ff, cap_in;
   logic [7:0]       count_ff, count_in;
   logic             skip_ff, skip_in;
   logic             desc_valid_ff, desc_valid_in;
   tle_pkg::run_type desc_ff, desc_in;
   logic             desc_take;
   logic             req_accept;
   logic [8:0]       cap_eff;
   logic [8:0]       limit;
   logic [8:0]       next_wide;

   assign req_stall     = desc_valid_ff && !desc_take;
   assign req_accept    = req_valid && !req_stall;
   assign desc_valid_in = req_accept || (desc_valid_ff && !desc_take);

   always_comb begin
      cap_in = cap_ff;
      if (csr_write_enable && csr_index == tle_pkg::CSR_LINE_CAPACITY) begin
         cap_in = csr_write_data;
      end
   end

   always_comb begin
      cap_eff = cap_ff;
      if (cap_ff < tle_pkg::CAP_MIN) begin
         cap_eff = tle_pkg::CAP_MIN;
      end else if (cap_ff > tle_pkg::CAP_MAX) begin
         cap_eff = tle_pkg::CAP_MAX;
      end
      limit     = cap_eff - 9'd1;
      next_wide = {1'b0, count_ff} + 9'd1;

      desc_in.kind    = tle_pkg::RUN_ECHO;
      desc_in.rx_char = req_received_char;
      desc_in.index   = count_ff;
      desc_in.next    = next_wide[7:0];
      desc_in.done    = 1'b0;
      count_in        = count_ff;
      skip_in         = 1'b0;

      if (!skip_ff && req_received_char == tle_pkg::CHAR_CR) begin
         skip_in = 1'b1;
      end else if (req_received_char == tle_pkg::CHAR_BS ||
                   req_received_char == tle_pkg::CHAR_DEL) begin
         if (count_ff != 8'd0) begin
            desc_in.kind = tle_pkg::RUN_ERASE;
            count_in     = count_ff - 8'd1;
         end
      end else begin
         desc_in.kind = tle_pkg::RUN_STORE;
         desc_in.done = (req_received_char == tle_pkg::CHAR_LF) || (next_wide >= limit);
         if (next_wide[8]) begin
            // full 8-bit index range used up
            desc_in.next = 8'd255;
            desc_in.done = 1'b1;
         end
         count_in = desc_in.done ? 8'd0 : next_wide[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= tle_pkg::CAP_RESET;
         count_ff      <= 8'd0;
         skip_ff       <= 1'b0;
         desc_valid_ff <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         desc_valid_ff <= desc_valid_in;
         if (req_accept) begin
            count_ff <= count_in;
            skip_ff  <= skip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         desc_ff <= desc_in;
      end
   end

   tle_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .desc_valid      (desc_valid_ff),
      .desc            (desc_ff),
      .desc_take       (desc_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_write_valid (rsp_write_valid),
      .rsp_write_index (rsp_write_index),
      .rsp_write_char  (rsp_write_char),
      .rsp_line_done   (rsp_line_done),
      .rsp_line_length (rsp_line_length),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
